// File: design/i2c_master_bit_sequencer_assert.svh
// Assertion macros for the I2C master bit sequencer checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// Checked at every edge outside reset.
`define I2CMBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("i2cmbs assertion failed");

// Checked at every edge, reset included.
`define I2CMBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2cmbs assertion failed");

`endif

// File: design/i2cmbs_pkg.sv
// Shared types and constants of the I2C master bit sequencer.
// No dependencies; imported by every module of the block.
package i2cmbs_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PHASE_W = 4;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  // register index taken from paddr[2]
  localparam logic REG_ACK_TIMEOUT = 1'b0;

  // command codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_STA_A = 4'd1;
  localparam logic [PHASE_W-1:0] PH_STA_B = 4'd2;
  localparam logic [PHASE_W-1:0] PH_STO_A = 4'd3;
  localparam logic [PHASE_W-1:0] PH_STO_B = 4'd4;
  localparam logic [PHASE_W-1:0] PH_WR_HI = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WR_LO = 4'd6;
  localparam logic [PHASE_W-1:0] PH_WR_NX = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RD_HI = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RD_LO = 4'd9;
  localparam logic [PHASE_W-1:0] PH_AK_HI = 4'd10;
  localparam logic [PHASE_W-1:0] PH_AK_LO = 4'd11;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 4'd12;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } out_t;

endpackage

// File: design/i2cmbs_apb_regs.sv
// APB-style configuration register file: holds ack_timeout.
// Depends on i2cmbs_pkg.
module i2cmbs_apb_regs import i2cmbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [7:0]         ack_timeout_o
);

  logic [7:0] ack_timeout_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ACK_TIMEOUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      ack_timeout_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[2])
      REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign ack_timeout_o = ack_timeout_q;

endmodule

// File: design/i2cmbs_core.sv
// Sequencer state and one-item step logic; the state registers double as
// the result register. Depends on i2cmbs_pkg.
module i2cmbs_core import i2cmbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_t        item_i,
  input  logic [7:0] ack_timeout_i,
  output out_t       res_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [2:0]         bit_cnt_q, bit_cnt_d;
  logic [7:0]         shift_q, shift_d;
  logic [7:0]         wait_cnt_q, wait_cnt_d;
  logic               ack_choice_q, ack_choice_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               drive_q, drive_d;
  logic               err_q, err_d;
  logic [7:0]         rx_q, rx_d;
  logic               done_q, done_d;
  logic [7:0]         shift_nx;

  assign shift_nx = {shift_q[6:0], 1'b0};

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    wait_cnt_d   = wait_cnt_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    drive_d      = drive_q;
    err_d        = err_q;
    rx_d         = rx_q;
    done_d       = 1'b0;

    if (item_i.kind == KIND_CMD) begin
      if (phase_q == PH_IDLE && item_i.op <= OP_WAIT) begin
        err_d      = 1'b0;
        bit_cnt_d  = 3'd0;
        wait_cnt_d = 8'd0;
        unique case (item_i.op)
          OP_START: begin
            drive_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; phase_d = PH_STA_A;
          end
          OP_STOP: begin
            drive_d = 1'b1; sda_d = 1'b0; scl_d = 1'b0; phase_d = PH_STO_A;
          end
          OP_WRITE: begin
            shift_d = item_i.tx_byte;
            drive_d = 1'b1; scl_d = 1'b0; sda_d = item_i.tx_byte[7];
            phase_d = PH_WR_HI;
          end
          OP_READ: begin
            shift_d      = 8'd0;
            ack_choice_d = item_i.ack_after_read;
            drive_d = 1'b0; scl_d = 1'b0; phase_d = PH_RD_HI;
          end
          default: begin
            drive_d = 1'b0; scl_d = 1'b1; phase_d = PH_WAIT;
          end
        endcase
      end
    end else if (phase_q != PH_IDLE) begin
      unique case (phase_q)
        PH_STA_A: begin sda_d = 1'b0; phase_d = PH_STA_B; end
        PH_STA_B: begin scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1; end
        PH_STO_A: begin scl_d = 1'b1; phase_d = PH_STO_B; end
        PH_STO_B: begin sda_d = 1'b1; phase_d = PH_IDLE; done_d = 1'b1; end
        PH_WR_HI: begin scl_d = 1'b1; phase_d = PH_WR_LO; end
        PH_WR_LO: begin scl_d = 1'b0; phase_d = PH_WR_NX; end
        PH_WR_NX: begin
          if (bit_cnt_q == LAST_BIT) begin
            sda_d = 1'b1; phase_d = PH_IDLE; done_d = 1'b1;
          end else begin
            bit_cnt_d = bit_cnt_q + 3'd1;
            shift_d   = shift_nx;
            sda_d     = shift_nx[7];
            phase_d   = PH_WR_HI;
          end
        end
        PH_RD_HI: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], item_i.sda_sample};
          phase_d = PH_RD_LO;
        end
        PH_RD_LO: begin
          scl_d = 1'b0;
          if (bit_cnt_q == LAST_BIT) begin
            rx_d    = shift_q;
            drive_d = 1'b1;
            sda_d   = !ack_choice_q;
            phase_d = PH_AK_HI;
          end else begin
            bit_cnt_d = bit_cnt_q + 3'd1;
            phase_d   = PH_RD_HI;
          end
        end
        PH_AK_HI: begin scl_d = 1'b1; phase_d = PH_AK_LO; end
        PH_AK_LO: begin scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1; end
        PH_WAIT: begin
          if (!item_i.sda_sample) begin
            scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1;
          end else if (wait_cnt_q >= ack_timeout_i) begin
            // timeout: fall into the stop sequence
            err_d = 1'b1; drive_d = 1'b1; sda_d = 1'b0; scl_d = 1'b0;
            phase_d = PH_STO_A;
          end else begin
            wait_cnt_d = wait_cnt_q + 8'd1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= 3'd0;
      shift_q      <= 8'd0;
      wait_cnt_q   <= 8'd0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      drive_q      <= 1'b1;
      err_q        <= 1'b0;
      rx_q         <= 8'd0;
      done_q       <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      wait_cnt_q   <= wait_cnt_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      drive_q      <= drive_d;
      err_q        <= err_d;
      rx_q         <= rx_d;
      done_q       <= done_d;
    end
  end

  always_comb begin
    res_o             = '0;
    res_o.scl_level   = scl_q;
    res_o.sda_level   = sda_q;
    res_o.sda_drive   = drive_q;
    res_o.busy_res    = (phase_q != PH_IDLE);
    res_o.done_res    = done_q;
    res_o.rx_byte     = rx_q;
    res_o.ack_missing = err_q;
  end

endmodule

// File: design/i2c_master_bit_sequencer.sv
// Channel  | dir | handshake               | beat
// in       | in  | in_valid_i / in_ready_o | in_t: command or tick
// out      | out | out_valid_o/out_ready_i | out_t: line levels and status
// apb      | in  | psel/penable, pready=1  | ack_timeout at byte address 0
//
// One beat in gives one beat out; one item per clock when out is not stalled.
// Beats pass the input register, then the step that updates the
// sequencer state, which is also the result register.
// A stalled output holds the state; the input register still takes one beat.
// Reset is asynchronous, active low; no clearing pass.
// Top level of the I2C master bit sequencer. Depends on i2cmbs_pkg,
// i2cmbs_apb_regs and i2cmbs_core.
module i2c_master_bit_sequencer import i2cmbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       in_valid_q;
  in_t        in_q;
  logic       out_valid_q;
  logic       advance;
  logic [7:0] ack_timeout;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  i2cmbs_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .ack_timeout_o (ack_timeout)
  );

  i2cmbs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .ack_timeout_i (ack_timeout),
    .res_o         (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// File: design/i2cmbs_checker.sv
// Port-level checker for the I2C master bit sequencer, bound to the top.
// Depends on i2cmbs_pkg and i2c_master_bit_sequencer_assert.svh.
`include "i2c_master_bit_sequencer_assert.svh"

module i2cmbs_checker import i2cmbs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // result beat holds while stalled
  `I2CMBS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // a finishing beat leaves the sequencer idle
  `I2CMBS_ASSERT(a_done_idle, clk_i, rst_ni, out_data_o.done_res |-> !out_data_o.busy_res)

  // timeout runs the stop sequence, so SDA stays driven while the flag is up
  `I2CMBS_ASSERT(a_err_drive, clk_i, rst_ni, out_data_o.ack_missing |-> out_data_o.sda_drive)

  // an edge seen in reset leaves both handshake registers empty
  `I2CMBS_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_o && in_ready_o)

endmodule

bind i2c_master_bit_sequencer i2cmbs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
